// ----- rtl/core/qr_reed_solomon_ecc_encoder_top_assert.svh -----
// Assertion macros for the RS encoder checker.
`ifndef QR_REED_SOLOMON_ECC_ENCODER_TOP_ASSERT_SVH
`define QR_REED_SOLOMON_ECC_ENCODER_TOP_ASSERT_SVH

// Next-cycle implication, masked while reset is asserted.
`define QRRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrrs check failed");

// Next-cycle implication that also holds across reset.
`define QRRS_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qrrs check failed");

`endif

// ----- rtl/core/qrrs_pkg.sv -----
`default_nettype none
package qrrs_pkg;

  localparam int MAX_PARITY = 30;
  localparam int CNT_W      = $clog2(MAX_PARITY + 1);
  localparam int PC_W       = 5;
  localparam logic [PC_W-1:0] PC_RESET  = 5'd7;
  localparam logic [7:0]      GF_REDUCE = 8'h1D;
  localparam logic [7:0]      GF_ONE    = 8'h01;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic       build_init;
    logic       build_step;
    logic       absorb;
    logic       load;
    logic       shift;
    logic [7:0] root;
    logic [7:0] factor;
  } cell_ctl_t;

  // Multiply by alpha (x) in GF(256) mod 0x11D.
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qrrs_in_if.sv -----
`default_nettype none
interface qrrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/qrrs_out_if.sv -----
`default_nettype none
interface qrrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       parity_last;

  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/qr_reed_solomon_ecc_encoder_top.sv -----
`default_nettype none
// Channel | Dir | Handshake           | Payload
// in_ch   | in  | valid/ready         | data_byte[7:0], block_end
// out_ch  | out | valid/ready         | parity_byte[7:0], parity_last
// cfg     | in  | cfg_we (no ready)   | cfg_wdata[4:0] = parity count
//
// One data byte per ready cycle; every cell folds the shared feedback into its tap at once.
// After reset or a cfg write the generator is rebuilt; in_ch.ready stays low in INIT and STEP.
// Parity leaves a separate shift chain from the cycle after block end, one per ready cycle.
// A block end waits while earlier parity bytes remain, unless the final one leaves that cycle.
// rst_n is synchronous, active low; it reloads the count to 7 and starts a build.
module qr_reed_solomon_ecc_encoder_top (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire [qrrs_pkg::PC_W-1:0] cfg_wdata,
  qrrs_in_if.sink                  in_ch,
  qrrs_out_if.source               out_ch
);
  import qrrs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [7:0]       root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] deg;

  cell_ctl_t  ctl;
  logic [7:0] g_w   [MAX_PARITY+1];
  logic [7:0] rem_w [MAX_PARITY+1];
  logic [7:0] par_w [MAX_PARITY+1];

  logic in_acc, out_acc, load_ok;

  // Clamp parity count into 1..MAX_PARITY.
  always_comb begin
    if (pc_r == '0)                  deg = CNT_W'(1);
    else if (int'(pc_r) > MAX_PARITY) deg = CNT_W'(MAX_PARITY);
    else                              deg = CNT_W'(pc_r);
  end

  // New burst can load when the drain chain is empty or emptying now.
  assign load_ok = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE) && (!in_ch.block_end || load_ok);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    ctl.build_init = (state_r == ST_INIT);
    ctl.build_step = (state_r == ST_STEP);
    ctl.absorb     = in_acc;
    ctl.load       = in_acc && in_ch.block_end;
    ctl.shift      = out_acc;
    ctl.root       = root_r;
    ctl.factor     = in_ch.data_byte ^ rem_w[0];
  end

  // Build sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    step_nxt  = step_r;
    root_nxt  = root_r;
    unique case (state_r)
      ST_INIT: begin
        step_nxt  = '0;
        root_nxt  = GF_ONE;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        step_nxt = step_r + CNT_W'(1);
        root_nxt = gf_xtime(root_r);
        if (step_r == deg - CNT_W'(1)) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      pc_nxt    = cfg_wdata;
      state_nxt = ST_INIT;
    end
  end

  // Parity drain count
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.load)     cnt_nxt = deg;
    else if (out_acc) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      pc_r    <= PC_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    root_r <= root_nxt;
  end

  assign g_w[MAX_PARITY]   = 8'h00;
  assign rem_w[MAX_PARITY] = 8'h00;
  assign par_w[MAX_PARITY] = 8'h00;

  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
    qrrs_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .init_one (deg == CNT_W'(i + 1)),
      .g_next   (g_w[i+1]),
      .rem_next (rem_w[i+1]),
      .par_next (par_w[i+1]),
      .g_q      (g_w[i]),
      .rem_q    (rem_w[i]),
      .par_q    (par_w[i])
    );
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.parity_byte = par_w[0];
  assign out_ch.parity_last = (cnt_r == CNT_W'(1));

endmodule
`default_nettype wire

// ----- rtl/core/qrrs_cell.sv -----
`default_nettype none
// One tap of the encoder: generator coefficient, remainder byte, parity byte.
module qrrs_cell (
  input  wire                    clk,
  input  qrrs_pkg::cell_ctl_t    ctl,
  input  wire                    init_one,
  input  wire  [7:0]             g_next,
  input  wire  [7:0]             rem_next,
  input  wire  [7:0]             par_next,
  output logic [7:0]             g_q,
  output logic [7:0]             rem_q,
  output logic [7:0]             par_q
);
  import qrrs_pkg::*;

  logic [7:0] g_r, g_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] par_r, par_nxt;
  logic [7:0] rem_upd;

  assign rem_upd = rem_next ^ gf_mul(g_r, ctl.factor);

  always_comb begin
    g_nxt   = g_r;
    rem_nxt = rem_r;
    par_nxt = par_r;
    if (ctl.build_init) begin
      g_nxt   = init_one ? GF_ONE : 8'h00;
      rem_nxt = 8'h00;
    end else if (ctl.build_step) begin
      g_nxt = gf_mul(g_r, ctl.root) ^ g_next;
    end
    if (ctl.absorb) begin
      rem_nxt = ctl.load ? 8'h00 : rem_upd;
    end
    if (ctl.load) begin
      par_nxt = rem_upd;
    end else if (ctl.shift) begin
      par_nxt = par_next;
    end
  end

  always_ff @(posedge clk) begin
    g_r   <= g_nxt;
    rem_r <= rem_nxt;
    par_r <= par_nxt;
  end

  assign g_q   = g_r;
  assign rem_q = rem_r;
  assign par_q = par_r;

endmodule
`default_nettype wire

// ----- rtl/core/qrrs_checker.sv -----
`default_nettype none
`include "qr_reed_solomon_ecc_encoder_top_assert.svh"
module qrrs_checker (
  input wire clk,
  input wire rst_n,
  input wire cfg_we,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire [7:0] out_parity_byte
);
  // held output item
  `QRRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `QRRS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_parity_byte))
  // generator rebuild blocks input
  `QRRS_ASSERT_NEXT(a_cfg_busy, cfg_we, !in_ready)
  `QRRS_ASSERT_NEXT_RST(a_rst_busy, !rst_n, !in_ready && !out_valid)
endmodule

bind qr_reed_solomon_ecc_encoder_top qrrs_checker u_qrrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_we          (cfg_we),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_parity_byte (out_ch.parity_byte)
);
`default_nettype wire

// ----- test/tb_qr_reed_solomon_ecc_encoder_top.sv -----
module tb_qr_reed_solomon_ecc_encoder_top;
  import qrrs_pkg::*;

  // Run limits and pacing
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;    // lets a trailing data byte land before a count write
  localparam int TAIL_CYCLES   = 40;   // quiet time at the end, catches stray parity bytes
  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off used to back the block up
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 25;

  // Directed stimulus: a count write or one data byte. Rows flagged typed carry the
  // parity byte that every position of the block must show, read straight off the code.
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;       // data byte, or the parity count in bits 4:0
    logic       last;
    logic       typed;
    logic [7:0] typed_byte;
  } row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } parity_t;

  // Receiver stall styles, picked afresh for each window
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_MASK} stall_mode_e;

  localparam int NUM_DIRECTED = 24;
  localparam row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // count 7 straight out of reset: a zero message gives zero parity
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, 8'h00},
    // half-fed block, then a count write throws it away
    '{ROW_ITEM, 8'h55, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  8'd30, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'hAA, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, 8'h00},
    // count zero runs as one parity byte: g(x) = x + 1, so parity equals the byte
    '{ROW_CFG,  8'd0,  1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b1, 8'h01},
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM, 8'h12, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h34, 1'b1, 1'b0, 8'h00},
    // count above the ceiling clamps to thirty
    '{ROW_CFG,  8'd31, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h7F, 1'b1, 1'b0, 8'h00},
    // smallest legal count
    '{ROW_CFG,  8'd1,  1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h80, 1'b1, 1'b1, 8'h80},
    '{ROW_CFG,  8'd2,  1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'hFE, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, 8'h00}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [PC_W-1:0]     cfg_wdata;

  qrrs_in_if  in_ch();
  qrrs_out_if out_ch();

  qr_reed_solomon_ecc_encoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Encoder model state: generator taps, remainder chain, current degree
  logic [7:0] gen_taps  [MAX_PARITY];
  logic [7:0] remainder [MAX_PARITY];
  int         gen_degree;

  parity_t    expected_parity [$];

  int fail_count;
  int cycle_count;
  int items_sent;
  int blocks_sent;
  int parity_checked;
  int counts_written;
  int burst_left;
  int hold_requests;

  // Clock: period 4, starts low
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d parity bytes outstanding",
               cycle_count, expected_parity.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Append one parity expectation at the tail of the queue
  function automatic void expect_parity(input logic [7:0] value, input logic last);
    parity_t item;
    item.value = value;
    item.last  = last;
    expected_parity.insert(expected_parity.size(), item);
  endfunction

  // GF(256) product, Horner form over the bits of b, reduced by 0x11D
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    prod = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      prod = {prod[6:0], 1'b0} ^ (prod[7] ? GF_REDUCE : 8'h00);
      if (b[i]) prod = prod ^ a;
    end
    return prod;
  endfunction

  // Multiply out (x - a^0)(x - a^1)...(x - a^(d-1)); leading 1 is implicit.
  // Also clears the remainder, as the block does on every count write.
  function automatic void rebuild_generator(input logic [PC_W-1:0] count);
    logic [7:0] root;
    int         d;
    d = int'(count);
    if (d < 1) d = 1;
    if (d > MAX_PARITY) d = MAX_PARITY;
    gen_degree = d;
    for (int i = 0; i < MAX_PARITY; i++) begin
      gen_taps[i]  = 8'h00;
      remainder[i] = 8'h00;
    end
    gen_taps[d-1] = GF_ONE;
    root = GF_ONE;
    for (int i = 0; i < d; i++) begin
      for (int j = 0; j < d; j++) begin
        gen_taps[j] = gf_times(gen_taps[j], root);
        if (j + 1 < d) gen_taps[j] = gen_taps[j] ^ gen_taps[j+1];
      end
      root = gf_times(root, 8'h02);
    end
  endfunction

  // Shift one data byte into the remainder; on a block end, queue the parity
  // bytes (when asked) and clear the chain for the next block.
  function automatic void encode_byte(input logic [7:0] data, input logic last,
                                      input logic queue_parity);
    logic [7:0] feedback;
    feedback = data ^ remainder[0];
    for (int i = 0; i + 1 < gen_degree; i++) remainder[i] = remainder[i+1];
    remainder[gen_degree-1] = 8'h00;
    for (int i = 0; i < gen_degree; i++)
      remainder[i] = remainder[i] ^ gf_times(gen_taps[i], feedback);
    if (last) begin
      if (queue_parity) begin
        for (int i = 0; i < gen_degree; i++)
          expect_parity(remainder[i], (i == gen_degree - 1));
      end
      for (int i = 0; i < MAX_PARITY; i++) remainder[i] = 8'h00;
      blocks_sent++;
    end
  endfunction

  // Offer one data byte in bursts with random gaps; the expectation is
  // worked out at the edge where the byte is taken.
  task automatic offer_item(input logic [7:0] data, input logic last,
                            input logic typed, input logic [7:0] typed_byte);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.block_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (typed) begin
      // hand-typed parity replaces the model's, model state still advances
      encode_byte(data, last, 1'b0);
      if (last) begin
        for (int i = 0; i < gen_degree; i++)
          expect_parity(typed_byte, (i == gen_degree - 1));
      end
    end else begin
      encode_byte(data, last, 1'b1);
    end
  endtask

  // Sender goes quiet until every queued parity byte has come out, then a
  // few more cycles so a trailing data byte has surely landed.
  task automatic drain_sender();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_parity.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Count writes only on an idle block; the write rebuilds the generator,
  // during which the block holds ready low, so no fixed wait is needed after.
  task automatic write_parity_count(input logic [PC_W-1:0] count);
    drain_sender();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rebuild_generator(count);
    counts_written++;
  endtask

  // Receiver: a stall style per window of random length, plus a long
  // hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int          hold_seen;
    int          hold_left;
    int          window;
    stall_mode_e mode;
    logic [7:0]  mask;
    hold_seen    = 0;
    hold_left    = 0;
    window       = 0;
    mode         = STALL_NONE;
    mask         = 8'hFF;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (window == 0) begin
        window = $urandom_range(16, 64);
        mode   = stall_mode_e'($urandom_range(0, 2));
        mask   = 8'($urandom);
      end
      window--;
      mask = {mask[6:0], mask[7]};
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE: out_ch.ready <= 1'b1;
          STALL_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
          default:    out_ch.ready <= mask[0];
        endcase
      end
    end
  end

  // Parity checker: each byte taken against the oldest expectation
  always @(posedge clk) begin : parity_check
    parity_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_parity.size() == 0) begin
        report_mismatch("parity byte with none expected", int'(out_ch.parity_byte), 0);
      end else begin
        want = expected_parity.pop_front();
        if (out_ch.parity_byte !== want.value)
          report_mismatch("parity_byte", int'(out_ch.parity_byte), int'(want.value));
        if (out_ch.parity_last !== want.last)
          report_mismatch("parity_last", int'(out_ch.parity_last), int'(want.last));
      end
      parity_checked++;
    end
  end

  initial begin : stimulus
    logic [PC_W-1:0] count;
    int              phase_items;
    int              len;
    logic            paused;
    fail_count      = 0;
    cycle_count     = 0;
    items_sent      = 0;
    blocks_sent     = 0;
    parity_checked  = 0;
    counts_written  = 0;
    burst_left      = 0;
    hold_requests   = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.block_end = 1'b0;
    rebuild_generator(PC_RESET);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG)
        write_parity_count(DIRECTED_ROWS[r].value[PC_W-1:0]);
      else
        offer_item(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].typed_byte);
    end

    // Random phases. First four pin the count extremes, the rest draw it.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       count = 5'd30;
        1:       count = 5'd1;
        2:       count = 5'd31;
        3:       count = 5'd0;
        default: count = PC_W'($urandom_range(0, 31));
      endcase
      write_parity_count(count);

      // Phase 0: receiver holds off while short blocks keep coming, so the
      // parity drain backs up and the block has to stall its input.
      if (phase == 0) begin
        @(posedge clk);
        hold_requests++;
      end

      phase_items = 0;
      paused      = 1'b0;
      while (phase_items < PHASE_ITEMS) begin
        if (phase == 0)
          len = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0)
          len = $urandom_range(9, 24);
        else
          len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          offer_item(8'($urandom_range(0, 255)), k == len - 1, 1'b0, 8'h00);
        phase_items += len;
        // one mid-phase pause in phase 2 until all parity is out
        if (phase == 2 && !paused && phase_items >= PHASE_ITEMS / 2) begin
          drain_sender();
          paused = 1'b1;
        end
      end

      // sometimes leave a block unfinished; the next write, if any, drops it
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++)
          offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_parity.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d data bytes in %0d blocks across %0d parity count writes,",
             items_sent, blocks_sent, counts_written);
    $display("with %0d parity bytes checked under random input gaps and output stalls.",
             parity_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
